[design/botq_pkg.sv]
// botq_pkg: shared types and constants for the box overlap table.
// No dependencies.
`default_nettype none
package botq_pkg;
	localparam logic [1:0] OP_REGISTER = 2'd0;
	localparam logic [1:0] OP_REMOVE   = 2'd1;
	localparam logic [1:0] OP_QUERY    = 2'd2;
	localparam logic [1:0] OP_CLEAR    = 2'd3;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_DISABLED = 2'd2;

	typedef struct packed {
		logic [7:0]         handle;
		logic [3:0]         box_type;
		logic signed [16:0] x;
		logic signed [16:0] y;
		logic [11:0]        width;
		logic [11:0]        height;
	} entry_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  handle;
		logic [3:0]  box_type;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] offset_x;
		logic signed [15:0] offset_y;
		logic [11:0] box_width;
		logic [11:0] box_height;
	} req_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] hit_handle;
		logic [1:0] status;
	} rsp_t;

	// Broadcast command seen by every cell of the chain.
	typedef struct packed {
		logic       shift_all;  // every cell takes its right neighbor's entry
		logic       shift_low;  // only cells below the bound shift
	} cell_ctl_t;
endpackage
`default_nettype wire

[design/botq_if.sv]
// botq_if: valid/ready channel carrying one payload.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface botq_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/botq_cell.sv]
// botq_cell: one table slot of the shifting chain.
// Depends on botq_pkg.
`default_nettype none
module botq_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  wire logic                clk,
	input  wire botq_pkg::cell_ctl_t ctl,
	input  wire logic [CW-1:0]       bound,
	input  wire botq_pkg::entry_t    next_entry,
	output botq_pkg::entry_t         entry_q
);
	logic en;

	// cells at or above the bound hold the kept run during a remove
	assign en = ctl.shift_all || (ctl.shift_low && (CW'(IDX) < bound));

	always_ff @(posedge clk) begin
		if (en) begin
			entry_q <= next_entry;
		end
	end
endmodule
`default_nettype wire

[design/box_overlap_table_query_top.sv]
// box_overlap_table_query_top: top level of the box overlap table.
// Depends on botq_pkg, botq_if, botq_cell.
`default_nettype none
// The table sits in a chain of MAX_ENTRIES cells that shift toward cell 0;
// the last cell takes either the entry leaving cell 0 or a new box. Live
// entries fill the top of the chain, cells MAX_ENTRIES-count up to
// MAX_ENTRIES-1, in table order. Register shifts the chain once at the
// transfer edge and drops the new box into the last cell. Query and remove
// walk the whole chain: MAX_ENTRIES shifts bring every cell past cell 0 in
// table order and put everything back. Query keeps the first hit. Remove
// shifts only the cells below the kept run when an entry is dropped, which
// squeezes it out and leaves the kept ones in order at the top. Query and
// remove results are valid once the walk ends and the state moves to S_OUT;
// register, clear, a register to a full table and anything but clear while
// disabled answer the cycle after. One item at a time: the next request is
// taken the cycle after the result transfers. Writes to enabled are taken on
// any config transfer; make them only while no item is in flight.
module box_overlap_table_query_top #(
	parameter int MAX_ENTRIES = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	botq_if.sink     req,
	botq_if.source   rsp,
	input  wire logic cfg_valid,
	output logic     cfg_ready,
	input  wire logic cfg_data
);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0]          state_q;
	logic                enabled_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       step_q;   // walk cycles done
	logic [CW-1:0]       keep_q;   // entries kept so far during remove
	botq_pkg::req_t      cur_q;
	botq_pkg::rsp_t      rsp_q;
	botq_pkg::cell_ctl_t ctl;
	botq_pkg::entry_t    chain [MAX_ENTRIES];
	botq_pkg::entry_t    new_entry;
	botq_pkg::entry_t    head;
	botq_pkg::entry_t    tail_in;
	logic [CW-1:0]       bound;
	logic [1:0]          st_in;
	logic                in_xfer;
	logic                walking;
	logic                is_query;
	logic                is_remove;
	logic                load;
	logic                head_live;
	logic                keep_now;
	logic                last_step;
	logic                ovl;
	logic                first_hit;
	logic signed [17:0]  q_x, q_y, q_w, q_h;
	logic signed [17:0]  e_x, e_y, e_w, e_h;

	assign cfg_ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);
	assign in_xfer   = req.valid && req.ready;
	assign rsp.valid = (state_q == S_OUT);
	assign rsp.data  = rsp_q;

	assign walking   = (state_q == S_WALK);
	assign is_query  = (cur_q.operation == botq_pkg::OP_QUERY);
	assign is_remove = (cur_q.operation == botq_pkg::OP_REMOVE);
	assign head      = chain[0];
	assign last_step = (step_q == CW'(MAX_ENTRIES - 1));

	// New box comes straight off the request; it enters at the transfer edge
	always_comb begin
		new_entry.handle   = req.data.handle;
		new_entry.box_type = req.data.box_type;
		new_entry.x        = 17'(req.data.pos_x) + 17'(req.data.offset_x);
		new_entry.y        = 17'(req.data.pos_y) - 17'(req.data.offset_y);
		new_entry.width    = req.data.box_width;
		new_entry.height   = req.data.box_height;
	end

	assign load = in_xfer && (req.data.operation == botq_pkg::OP_REGISTER) &&
	              enabled_q && (count_q != CW'(MAX_ENTRIES));

	// Step k shows original cell k at the head; live run starts at N-count
	assign head_live = (step_q >= CW'(MAX_ENTRIES) - count_q);
	assign keep_now  = head_live && (head.handle != cur_q.handle);
	assign bound     = CW'(MAX_ENTRIES) - keep_q;
	assign tail_in   = load ? new_entry : head;

	always_comb begin
		ctl.shift_all = load || (walking && (is_query || (is_remove && keep_now)));
		ctl.shift_low = walking && is_remove && !keep_now;
	end

	// Strict overlap on both axes; all sums fit in 18 bits
	always_comb begin
		q_x = 18'(cur_q.pos_x) + 18'(cur_q.offset_x);
		q_y = 18'(cur_q.pos_y) - 18'(cur_q.offset_y);
		q_w = $signed({6'd0, cur_q.box_width});
		q_h = $signed({6'd0, cur_q.box_height});
		e_x = 18'(head.x);
		e_y = 18'(head.y);
		e_w = $signed({6'd0, head.width});
		e_h = $signed({6'd0, head.height});
		ovl = (q_x < e_x + e_w) && (q_x + q_w > e_x) &&
		      (q_y < e_y + e_h) && (q_y + q_h > e_y);
	end

	assign first_hit = walking && is_query && head_live && !rsp_q.hit &&
	                   (head.handle != cur_q.handle) &&
	                   (head.box_type == cur_q.box_type) && ovl;

	always_comb begin
		st_in = botq_pkg::ST_DONE;
		if (req.data.operation != botq_pkg::OP_CLEAR && !enabled_q)
			st_in = botq_pkg::ST_DISABLED;
		else if (req.data.operation == botq_pkg::OP_REGISTER &&
		         count_q == CW'(MAX_ENTRIES))
			st_in = botq_pkg::ST_FULL;
	end

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		botq_cell #(.IDX(g), .CW(CW)) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.bound      (bound),
			.next_entry ((g == MAX_ENTRIES - 1) ? tail_in : chain[(g + 1) % MAX_ENTRIES]),
			.entry_q    (chain[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			enabled_q <= 1'b0;
			count_q   <= '0;
			step_q    <= '0;
			keep_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) enabled_q <= cfg_data;
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						step_q <= '0;
						keep_q <= '0;
						if (req.data.operation == botq_pkg::OP_CLEAR) begin
							count_q <= '0;
							state_q <= S_OUT;
						end else if (!enabled_q) begin
							state_q <= S_OUT;
						end else if (req.data.operation == botq_pkg::OP_REGISTER) begin
							if (load) count_q <= count_q + CW'(1);
							state_q <= S_OUT;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					step_q <= step_q + CW'(1);
					if (is_remove && keep_now) keep_q <= keep_q + CW'(1);
					if (last_step) begin
						state_q <= S_OUT;
						if (is_remove)
							count_q <= keep_q + CW'(keep_now);
					end
				end
				S_OUT: begin
					if (rsp.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cur_q <= req.data;
			rsp_q <= {1'b0, 8'd0, st_in};
		end else if (first_hit) begin
			rsp_q <= {1'b1, head.handle, rsp_q.status};
		end
	end

`ifndef ASSERT_OFF
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !rsp.valid) else $error("ready while result pending");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES)) else $error("count overflow");
	a_walk_len: assert property (@(posedge clk) disable iff (!arst_n)
		walking |-> step_q < CW'(MAX_ENTRIES)) else $error("walk overran");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("result changed while waiting");
`endif
endmodule
`default_nettype wire
